/* sv/hnf_pkg.sv */
// ----------------------------------------------------------------------------
// hnf_pkg: shared types, constants and tables for the helium-nova fit
// Holds the fixed-point widths, the reference-curve coefficient tables, the
// rate thresholds, the mass knots and the data structs that move between the
// pipeline cells.
// ----------------------------------------------------------------------------
package hnf_pkg;

  // Fractional bits of log rate, mass, shift and result.
  localparam int FRAC_BITS = 24;

  localparam int LR_W   = 29;
  localparam int MASS_W = 26;
  localparam int CFG_W  = 26;
  localparam int ETA_W  = 28;
  localparam int IDX_W  = 4;
  localparam int PC_W   = 2;
  localparam int STEP_W = 3;
  localparam int ACC_W  = 64;
  localparam int D_W    = 34;
  localparam int XL_W   = 40;
  localparam int Y_W    = 43;
  localparam int M100_W = 33;

  localparam int NUM_CURVES = 11;
  localparam int NUM_PIECES = 3;
  localparam int NUM_COEFS  = 5;

  // Horner accumulator limit and curve limit, in units of 2^-8 * 1e-8.
  localparam logic signed [ACC_W-1:0] ACC_LIM   = 64'sd1 <<< 62;
  localparam logic signed [ACC_W-1:0] CURVE_LIM = 64'sd1677721600000000;

  // Curve conversion: q = floor(u * 2^CVT_SH / 5^8), with u the biased value.
  localparam int CVT_SH   = FRAC_BITS - 16;
  localparam longint DEC_ODD = 64'sd390625;
  localparam int REC_K    = 60;
  localparam int U_W      = 52;
  localparam int QE_W     = 42;
  localparam logic [QE_W-1:0] REC_C = QE_W'((64'd1 << REC_K) / 64'd390625);
  localparam int CURVE_OFS_SH = 16 + FRAC_BITS;

  // Interpolation divide by the knot span, through a reciprocal.
  localparam int SPAN_K = 52;
  localparam int M_W    = 50;
  localparam int SREC_W = 50;
  localparam int SPAN_W = 6;

  // Thresholds in thousandths of x: piece 0 above the first, piece 1 above
  // the second, piece 2 otherwise.
  localparam longint THR [NUM_CURVES][2] = '{
    '{-64'sd7421, -64'sd7421}, '{-64'sd6921, -64'sd6921},
    '{-64'sd6495, -64'sd6495}, '{-64'sd6585, -64'sd6585},
    '{-64'sd6155, -64'sd7046}, '{-64'sd5921, -64'sd7097},
    '{-64'sd5854, -64'sd7222}, '{-64'sd5824, -64'sd7222},
    '{-64'sd5824, -64'sd7222}, '{-64'sd5824, -64'sd7301},
    '{-64'sd5824, -64'sd7301}
  };

  // Polynomial coefficients c0..c4 in units of 1e-8, per curve and piece.
  localparam longint COEF [NUM_CURVES][NUM_PIECES][NUM_COEFS] = '{
    '{'{64'sd36452339925814, 64'sd19987615570843, 64'sd4109777848236,
        64'sd375562839546, 64'sd12869653622},
      '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd49440000, 64'sd2840000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd27439830600877, 64'sd16153075025466, 64'sd3565738069353,
        64'sd349823532301, 64'sd12869653622},
      '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd42140000, 64'sd2710000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd24131571447017, 64'sd11140451221858, 64'sd1702557779911,
        64'sd84292305137, -64'sd281727160},
      '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd57740000, 64'sd3760000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd64742588293061, 64'sd40084420977850, 64'sd9306148887580,
        64'sd960191634884, 64'sd37149410540},
      '{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd45980000, 64'sd3280000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd5167400000, 64'sd831150000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd2166204702, 64'sd608106227, 64'sd42950525, 64'sd0, 64'sd0},
      '{64'sd33100000, 64'sd2740000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd5035800000, 64'sd838560000, 64'sd0, 64'sd0, 64'sd0},
      '{-64'sd30630153647, -64'sd19828033421, -64'sd4722636728,
        -64'sd492869779, -64'sd19075473},
      '{64'sd29870000, 64'sd2750000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd4014600000, 64'sd672160000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd117446712731, 64'sd70815701427, 64'sd16039740390,
        64'sd1616260323, 64'sd61101079},
      '{64'sd29940000, 64'sd2780000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd4360400000, 64'sd734030000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd134209332478, 64'sd81182891151, 64'sd18434484390,
        64'sd1861070131, 64'sd70445443},
      '{64'sd29240000, 64'sd2780000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd3139700000, 64'sd524460000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd69571187519, 64'sd41689622203, 64'sd9397568200,
        64'sd943073062, 64'sd35511452},
      '{64'sd27540000, 64'sd2780000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd2849700000, 64'sd474200000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd1131042978, 64'sd281395280, 64'sd17534165, 64'sd0, 64'sd0},
      '{64'sd31500000, 64'sd2800000, 64'sd0, 64'sd0, 64'sd0}},
    '{'{64'sd2859700000, 64'sd474200000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd1141042978, 64'sd281395280, 64'sd17534165, 64'sd0, 64'sd0},
      '{64'sd41500000, 64'sd2800000, 64'sd0, 64'sd0, 64'sd0}}
  };

  // Mass knots in hundredths of a solar mass.
  localparam longint KNOT [NUM_CURVES] = '{
    64'sd20, 64'sd70, 64'sd80, 64'sd90, 64'sd100, 64'sd110,
    64'sd120, 64'sd125, 64'sd130, 64'sd135, 64'sd144
  };

  // Knot span of each bracket and its reciprocal scaled by 2^SPAN_K.
  localparam longint SPAN [NUM_CURVES-1] = '{
    64'sd50, 64'sd10, 64'sd10, 64'sd10, 64'sd10,
    64'sd10, 64'sd5, 64'sd5, 64'sd5, 64'sd9
  };
  localparam longint SPAN_REC [NUM_CURVES-1] = '{
    (64'sd1 <<< SPAN_K) / 50, (64'sd1 <<< SPAN_K) / 10,
    (64'sd1 <<< SPAN_K) / 10, (64'sd1 <<< SPAN_K) / 10,
    (64'sd1 <<< SPAN_K) / 10, (64'sd1 <<< SPAN_K) / 10,
    (64'sd1 <<< SPAN_K) / 5,  (64'sd1 <<< SPAN_K) / 5,
    (64'sd1 <<< SPAN_K) / 5,  (64'sd1 <<< SPAN_K) / 9
  };

  // Item state while the two curves go through the Horner cells.
  typedef struct packed {
    logic signed [LR_W-1:0]  lr;
    logic signed [D_W-1:0]   d;
    logic [IDX_W-1:0]        idx;
    logic [PC_W-1:0]         p_lo;
    logic [PC_W-1:0]         p_hi;
    logic signed [ACC_W-1:0] acc_lo;
    logic signed [ACC_W-1:0] acc_hi;
  } hrn_t;

  // Item state after both curves are converted and shifted.
  typedef struct packed {
    logic signed [Y_W-1:0] y_lo;
    logic signed [Y_W-1:0] y_hi;
    logic signed [D_W-1:0] d;
    logic [IDX_W-1:0]      idx;
  } crv_t;

  // Coefficient in units of 2^-8 * 1e-8.
  function automatic logic signed [ACC_W-1:0] coef_s(input logic [IDX_W-1:0] k,
                                                    input logic [PC_W-1:0] p,
                                                    input logic [STEP_W-1:0] s);
    return ACC_W'(COEF[k][p][s] <<< 8);
  endfunction

  // Mass knot in units of 2^-FRAC_BITS / 100.
  function automatic logic signed [D_W-1:0] knot_q(input logic [IDX_W-1:0] k);
    return D_W'(KNOT[k] <<< FRAC_BITS);
  endfunction

  // Rate threshold in units of 2^-FRAC_BITS / 1000.
  function automatic logic signed [XL_W-1:0] thr_q(input logic [IDX_W-1:0] k,
                                                   input logic j);
    return XL_W'(THR[k][j] <<< FRAC_BITS);
  endfunction

endpackage

/* sv/hnf_horner_cell.sv */
// ----------------------------------------------------------------------------
// hnf_horner_cell: one Horner step for both bracket curves
// First stage forms the split partial products of accumulator and log rate,
// second stage sums them, floors, saturates and adds the next coefficient.
// ----------------------------------------------------------------------------
module hnf_horner_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hnf_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  hnf_pkg::hrn_t                 item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output hnf_pkg::hrn_t                 item_o
);

  localparam int PL_W = 33 + hnf_pkg::LR_W;
  localparam int PH_W = 32 + hnf_pkg::LR_W;
  localparam int P_W  = PL_W + 31;
  localparam int S_W  = hnf_pkg::ACC_W + 1;

  logic                     a_v_q, b_v_q;
  logic                     a_rdy, b_rdy;
  hnf_pkg::hrn_t            a_item_q, b_item_q, b_item_d;
  logic signed [PL_W-1:0]   pl_lo_q, pl_hi_q, pl_lo_d, pl_hi_d;
  logic signed [PH_W-1:0]   ph_lo_q, ph_hi_q, ph_lo_d, ph_hi_d;

  // Handshake of the two stages.
  assign b_rdy   = !b_v_q || ready_i;
  assign a_rdy   = !a_v_q || b_rdy;
  assign ready_o = a_rdy;
  assign valid_o = b_v_q;
  assign item_o  = b_item_q;

  // Partial products of the accumulator halves and the log rate.
  always_comb begin
    pl_lo_d = $signed({1'b0, item_i.acc_lo[31:0]}) * item_i.lr;
    ph_lo_d = $signed(item_i.acc_lo[63:32]) * item_i.lr;
    pl_hi_d = $signed({1'b0, item_i.acc_hi[31:0]}) * item_i.lr;
    ph_hi_d = $signed(item_i.acc_hi[63:32]) * item_i.lr;
  end

  // Combine, floor-shift, saturate and add the coefficient.
  function automatic logic signed [hnf_pkg::ACC_W-1:0] step_acc(
      input logic signed [PL_W-1:0] pl, input logic signed [PH_W-1:0] ph,
      input logic signed [hnf_pkg::ACC_W-1:0] c);
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] lim;
    logic signed [S_W-1:0] s;
    logic signed [S_W-1:0] slim;
    lim  = P_W'(hnf_pkg::ACC_LIM);
    slim = S_W'(hnf_pkg::ACC_LIM);
    p = ((P_W'(ph)) <<< 32) + P_W'(pl);
    p = p >>> hnf_pkg::FRAC_BITS;
    if (p > lim) begin
      p = lim;
    end else if (p < -lim) begin
      p = -lim;
    end
    s = S_W'(p) + S_W'(c);
    if (s > slim) begin
      s = slim;
    end else if (s < -slim) begin
      s = -slim;
    end
    return hnf_pkg::ACC_W'(s);
  endfunction

  always_comb begin
    b_item_d        = a_item_q;
    b_item_d.acc_lo = step_acc(pl_lo_q, ph_lo_q,
                               hnf_pkg::coef_s(a_item_q.idx, a_item_q.p_lo, step_i));
    b_item_d.acc_hi = step_acc(pl_hi_q, ph_hi_q,
                               hnf_pkg::coef_s(hnf_pkg::IDX_W'(a_item_q.idx + 1'b1),
                                               a_item_q.p_hi, step_i));
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= valid_i;
      if (b_rdy) b_v_q <= a_v_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) begin
      a_item_q <= item_i;
      pl_lo_q  <= pl_lo_d;
      ph_lo_q  <= ph_lo_d;
      pl_hi_q  <= pl_hi_d;
      ph_hi_q  <= ph_hi_d;
    end
    if (b_rdy && a_v_q) begin
      b_item_q <= b_item_d;
    end
  end

endmodule

/* sv/hnf_curve_cvt.sv */
// ----------------------------------------------------------------------------
// hnf_curve_cvt: curve value to fixed point, shift and clamp
// Clamps each Horner result, divides it by 5^8 through a reciprocal with one
// correction step, removes the bias, adds the configured shift and clamps
// the sum to at most one.
// ----------------------------------------------------------------------------
module hnf_curve_cvt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [hnf_pkg::CFG_W-1:0]  eta_shift_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  hnf_pkg::hrn_t                     item_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output hnf_pkg::crv_t                     item_o
);

  localparam int UH_W = hnf_pkg::U_W / 2;
  localparam int RH_W = hnf_pkg::QE_W / 2;
  localparam int PP_W = UH_W + RH_W;
  localparam int SUM_W = hnf_pkg::U_W + hnf_pkg::QE_W;
  localparam int N_W = hnf_pkg::U_W + hnf_pkg::CVT_SH + 1;
  localparam int AW  = hnf_pkg::ACC_W;

  logic c1_v_q, c2_v_q, c3_v_q, c4_v_q;
  logic c1_rdy, c2_rdy, c3_rdy, c4_rdy;

  logic signed [hnf_pkg::D_W-1:0] d1_q, d2_q, d3_q;
  logic [hnf_pkg::IDX_W-1:0]      idx1_q, idx2_q, idx3_q;

  logic [hnf_pkg::U_W-1:0]  u_d [2];
  logic [hnf_pkg::U_W-1:0]  u1_q [2];
  logic [hnf_pkg::U_W-1:0]  u2_q [2];
  logic [hnf_pkg::U_W-1:0]  u3_q [2];
  logic [PP_W-1:0]          p11_q [2];
  logic [PP_W-1:0]          p10_q [2];
  logic [PP_W-1:0]          p01_q [2];
  logic [PP_W-1:0]          p00_q [2];
  logic [hnf_pkg::QE_W-1:0] qe_d [2];
  logic [hnf_pkg::QE_W-1:0] qe_q [2];
  logic signed [hnf_pkg::Y_W-1:0] y_d [2];
  hnf_pkg::crv_t            out_q;

  // Handshake along the four stages.
  assign c4_rdy  = !c4_v_q || ready_i;
  assign c3_rdy  = !c3_v_q || c4_rdy;
  assign c2_rdy  = !c2_v_q || c3_rdy;
  assign c1_rdy  = !c1_v_q || c2_rdy;
  assign ready_o = c1_rdy;
  assign valid_o = c4_v_q;
  assign item_o  = out_q;

  // Clamp to the curve limit and bias to a non-negative value.
  function automatic logic [hnf_pkg::U_W-1:0] bias_acc(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] c;
    c = a;
    if (c > hnf_pkg::CURVE_LIM) begin
      c = hnf_pkg::CURVE_LIM;
    end else if (c < -hnf_pkg::CURVE_LIM) begin
      c = -hnf_pkg::CURVE_LIM;
    end
    return hnf_pkg::U_W'(c + hnf_pkg::CURVE_LIM);
  endfunction

  // Reciprocal estimate from the four partial products.
  function automatic logic [hnf_pkg::QE_W-1:0] rec_sum(
      input logic [PP_W-1:0] p11, input logic [PP_W-1:0] p10,
      input logic [PP_W-1:0] p01, input logic [PP_W-1:0] p00);
    logic [SUM_W-1:0] s;
    s = (SUM_W'(p11) << (UH_W + RH_W)) + (SUM_W'(p10) << UH_W)
      + (SUM_W'(p01) << RH_W) + SUM_W'(p00);
    return hnf_pkg::QE_W'(s >> (hnf_pkg::REC_K - hnf_pkg::CVT_SH));
  endfunction

  // Correct the estimate, drop the bias, add the shift and clamp at one.
  function automatic logic signed [hnf_pkg::Y_W-1:0] finish_y(
      input logic [hnf_pkg::U_W-1:0] u, input logic [hnf_pkg::QE_W-1:0] qe,
      input logic signed [hnf_pkg::CFG_W-1:0] sh);
    logic [N_W-1:0] rem;
    logic [hnf_pkg::QE_W:0] q;
    logic signed [hnf_pkg::Y_W-1:0] v;
    logic signed [hnf_pkg::Y_W-1:0] one;
    one = hnf_pkg::Y_W'(64'sd1 <<< hnf_pkg::FRAC_BITS);
    rem = (N_W'(u) << hnf_pkg::CVT_SH) - N_W'(qe) * N_W'(hnf_pkg::DEC_ODD);
    q   = (hnf_pkg::QE_W + 1)'(qe);
    if (rem >= N_W'(hnf_pkg::DEC_ODD)) begin
      q = q + 1'b1;
    end
    v = $signed(hnf_pkg::Y_W'(q)) - hnf_pkg::Y_W'(64'sd1 <<< hnf_pkg::CURVE_OFS_SH)
      + hnf_pkg::Y_W'(sh);
    if (v > one) begin
      v = one;
    end
    return v;
  endfunction

  always_comb begin
    u_d[0] = bias_acc(item_i.acc_lo);
    u_d[1] = bias_acc(item_i.acc_hi);
    for (int i = 0; i < 2; i++) begin
      qe_d[i] = rec_sum(p11_q[i], p10_q[i], p01_q[i], p00_q[i]);
      y_d[i]  = finish_y(u3_q[i], qe_q[i], eta_shift_i);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
      c4_v_q <= 1'b0;
    end else begin
      if (c1_rdy) c1_v_q <= valid_i;
      if (c2_rdy) c2_v_q <= c1_v_q;
      if (c3_rdy) c3_v_q <= c2_v_q;
      if (c4_rdy) c4_v_q <= c3_v_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (c1_rdy && valid_i) begin
      u1_q   <= u_d;
      d1_q   <= item_i.d;
      idx1_q <= item_i.idx;
    end
    if (c2_rdy && c1_v_q) begin
      for (int i = 0; i < 2; i++) begin
        p11_q[i] <= PP_W'(u1_q[i][hnf_pkg::U_W-1:UH_W]) * PP_W'(hnf_pkg::REC_C[hnf_pkg::QE_W-1:RH_W]);
        p10_q[i] <= PP_W'(u1_q[i][hnf_pkg::U_W-1:UH_W]) * PP_W'(hnf_pkg::REC_C[RH_W-1:0]);
        p01_q[i] <= PP_W'(u1_q[i][UH_W-1:0]) * PP_W'(hnf_pkg::REC_C[hnf_pkg::QE_W-1:RH_W]);
        p00_q[i] <= PP_W'(u1_q[i][UH_W-1:0]) * PP_W'(hnf_pkg::REC_C[RH_W-1:0]);
      end
      u2_q   <= u1_q;
      d2_q   <= d1_q;
      idx2_q <= idx1_q;
    end
    if (c3_rdy && c2_v_q) begin
      qe_q   <= qe_d;
      u3_q   <= u2_q;
      d3_q   <= d2_q;
      idx3_q <= idx2_q;
    end
    if (c4_rdy && c3_v_q) begin
      out_q.y_lo <= y_d[0];
      out_q.y_hi <= y_d[1];
      out_q.d    <= d3_q;
      out_q.idx  <= idx3_q;
    end
  end

endmodule

/* sv/hnf_interp.sv */
// ----------------------------------------------------------------------------
// hnf_interp: linear interpolation in mass and output saturation
// Forms d * (yh - yl), floors by 2^FRAC_BITS, divides by the knot span
// through a reciprocal with one correction and adds the lower curve. The
// last stage is the output register.
// ----------------------------------------------------------------------------
module hnf_interp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  hnf_pkg::crv_t                     item_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [hnf_pkg::ETA_W-1:0]  eta_o,
  output logic                              sat_o
);

  localparam int DY_W  = hnf_pkg::Y_W + 1;
  localparam int DL_W  = 22;
  localparam int DH_W  = DY_W - DL_W;
  localparam int PL_W  = hnf_pkg::D_W + DL_W + 1;
  localparam int PH_W  = hnf_pkg::D_W + DH_W;
  localparam int X_W   = PH_W + DL_W + 1;
  localparam int MH_W  = hnf_pkg::M_W / 2;
  localparam int RH_W  = hnf_pkg::SREC_W / 2;
  localparam int PP_W  = MH_W + RH_W;
  localparam int SUM_W = hnf_pkg::M_W + hnf_pkg::SREC_W;
  localparam int T_W   = hnf_pkg::M_W + 2;
  localparam int YS_W  = T_W + 1;
  localparam int IW    = hnf_pkg::IDX_W;
  localparam int YW    = hnf_pkg::Y_W;

  logic i1_v_q, i2_v_q, i3_v_q, i4_v_q, i5_v_q;
  logic i1_rdy, i2_rdy, i3_rdy, i4_rdy, i5_rdy;

  logic signed [DY_W-1:0]  dy_d;
  logic signed [PL_W-1:0]  pl_q;
  logic signed [PH_W-1:0]  ph_q;
  logic signed [YW-1:0]    yl1_q, yl2_q, yl3_q, yl4_q;
  logic [IW-1:0]           idx1_q, idx2_q, idx3_q, idx4_q;
  logic                    neg2_q, neg3_q, neg4_q;
  logic [hnf_pkg::M_W-1:0] m_d, m2_q, m3_q, m4_q;
  logic                    neg_d;
  logic [hnf_pkg::SREC_W-1:0] rec_d;
  logic [PP_W-1:0]         p11_q, p10_q, p01_q, p00_q;
  logic [hnf_pkg::M_W-1:0] qe_d, qe_q;
  logic signed [hnf_pkg::ETA_W-1:0] eta_d, eta_q;
  logic                    sat_d, sat_q;

  // Handshake along the five stages.
  assign i5_rdy  = !i5_v_q || ready_i;
  assign i4_rdy  = !i4_v_q || i5_rdy;
  assign i3_rdy  = !i3_v_q || i4_rdy;
  assign i2_rdy  = !i2_v_q || i3_rdy;
  assign i1_rdy  = !i1_v_q || i2_rdy;
  assign ready_o = i1_rdy;
  assign valid_o = i5_v_q;
  assign eta_o   = eta_q;
  assign sat_o   = sat_q;

  assign dy_d = DY_W'(item_i.y_hi) - DY_W'(item_i.y_lo);

  // Floor the product by 2^FRAC_BITS and split off its sign.
  always_comb begin
    logic signed [X_W-1:0] x;
    x = (X_W'(ph_q) <<< DL_W) + X_W'(pl_q);
    x = x >>> hnf_pkg::FRAC_BITS;
    neg_d = x[X_W-1];
    m_d   = neg_d ? hnf_pkg::M_W'(-x) : hnf_pkg::M_W'(x);
  end

  assign rec_d = hnf_pkg::SREC_W'(hnf_pkg::SPAN_REC[idx2_q]);

  // Quotient estimate from the partial products.
  always_comb begin
    logic [SUM_W-1:0] s;
    s = (SUM_W'(p11_q) << (MH_W + RH_W)) + (SUM_W'(p10_q) << MH_W)
      + (SUM_W'(p01_q) << RH_W) + SUM_W'(p00_q);
    qe_d = hnf_pkg::M_W'(s >> hnf_pkg::SPAN_K);
  end

  // Correct the quotient, apply floor for a negative term, add and clip.
  always_comb begin
    logic [hnf_pkg::M_W-1:0]    rem;
    logic [hnf_pkg::SPAN_W-1:0] span;
    logic [T_W-1:0]             q;
    logic signed [T_W-1:0]      t;
    logic signed [YS_W-1:0]     y;
    logic signed [YS_W-1:0]     ymax;
    logic signed [YS_W-1:0]     ymin;
    span = hnf_pkg::SPAN_W'(hnf_pkg::SPAN[idx4_q]);
    ymax = YS_W'(64'sd1 <<< (hnf_pkg::ETA_W - 1)) - YS_W'(1);
    ymin = -YS_W'(64'sd1 <<< (hnf_pkg::ETA_W - 1));
    rem  = m4_q - hnf_pkg::M_W'(qe_q) * hnf_pkg::M_W'(span);
    q    = T_W'(qe_q);
    if (rem >= hnf_pkg::M_W'(span)) begin
      q   = q + 1'b1;
      rem = rem - hnf_pkg::M_W'(span);
    end
    if (neg4_q) begin
      if (rem != '0) begin
        q = q + 1'b1;
      end
      t = -$signed(q);
    end else begin
      t = $signed(q);
    end
    y = YS_W'(yl4_q) + YS_W'(t);
    sat_d = 1'b0;
    if (y > ymax) begin
      y     = ymax;
      sat_d = 1'b1;
    end else if (y < ymin) begin
      y     = ymin;
      sat_d = 1'b1;
    end
    eta_d = hnf_pkg::ETA_W'(y);
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_v_q <= 1'b0;
      i2_v_q <= 1'b0;
      i3_v_q <= 1'b0;
      i4_v_q <= 1'b0;
      i5_v_q <= 1'b0;
    end else begin
      if (i1_rdy) i1_v_q <= valid_i;
      if (i2_rdy) i2_v_q <= i1_v_q;
      if (i3_rdy) i3_v_q <= i2_v_q;
      if (i4_rdy) i4_v_q <= i3_v_q;
      if (i5_rdy) i5_v_q <= i4_v_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (i1_rdy && valid_i) begin
      pl_q   <= item_i.d * $signed({1'b0, dy_d[DL_W-1:0]});
      ph_q   <= item_i.d * $signed(dy_d[DY_W-1:DL_W]);
      yl1_q  <= item_i.y_lo;
      idx1_q <= item_i.idx;
    end
    if (i2_rdy && i1_v_q) begin
      m2_q   <= m_d;
      neg2_q <= neg_d;
      yl2_q  <= yl1_q;
      idx2_q <= idx1_q;
    end
    if (i3_rdy && i2_v_q) begin
      p11_q  <= PP_W'(m2_q[hnf_pkg::M_W-1:MH_W]) * PP_W'(rec_d[hnf_pkg::SREC_W-1:RH_W]);
      p10_q  <= PP_W'(m2_q[hnf_pkg::M_W-1:MH_W]) * PP_W'(rec_d[RH_W-1:0]);
      p01_q  <= PP_W'(m2_q[MH_W-1:0]) * PP_W'(rec_d[hnf_pkg::SREC_W-1:RH_W]);
      p00_q  <= PP_W'(m2_q[MH_W-1:0]) * PP_W'(rec_d[RH_W-1:0]);
      m3_q   <= m2_q;
      neg3_q <= neg2_q;
      yl3_q  <= yl2_q;
      idx3_q <= idx2_q;
    end
    if (i4_rdy && i3_v_q) begin
      qe_q   <= qe_d;
      m4_q   <= m3_q;
      neg4_q <= neg3_q;
      yl4_q  <= yl3_q;
      idx4_q <= idx3_q;
    end
    if (i5_rdy && i4_v_q) begin
      eta_q <= eta_d;
      sat_q <= sat_d;
    end
  end

endmodule

/* sv/helium_nova_retention_fit.sv */
// ----------------------------------------------------------------------------
// helium_nova_retention_fit: helium-nova retention efficiency
// Bracket and piece selection, a row of four Horner cells, curve conversion
// and mass interpolation, with valid/ready on both sides.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output side is
// not stalled, and returns one result per transaction, in order, through 18
// register stages. The stages are one entry stage, which loads the highest
// polynomial coefficient, four Horner cells of two stages each (one per
// remaining coefficient, set by the split 64 x 29 bit multiply), four stages
// of fixed-point conversion and five of interpolation. Each stage holds one
// transaction and passes it on as soon as the next is free, so a stalled
// output fills the pipeline before the input stops. The shift register
// should only be written while no transaction is in flight.
module helium_nova_retention_fit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic signed [hnf_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [hnf_pkg::LR_W-1:0]   log_rate_i,
  input  logic [hnf_pkg::MASS_W-1:0]        wd_mass_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hnf_pkg::ETA_W-1:0]  eta_o,
  output logic                              saturated_o
);

  localparam int NCELL = hnf_pkg::NUM_COEFS - 1;
  localparam int IW    = hnf_pkg::IDX_W;

  logic signed [hnf_pkg::CFG_W-1:0] eta_shift_q;
  logic                  e_v_q, e_rdy;
  hnf_pkg::hrn_t         e_item_q, e_item_d;
  logic                  h_v   [NCELL+1];
  logic                  h_rdy [NCELL+1];
  hnf_pkg::hrn_t         h_item [NCELL+1];
  logic                  c_v, c_rdy;
  hnf_pkg::crv_t         c_item;

  // Shift register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_shift_q <= '0;
    end else if (cfg_we_i) begin
      eta_shift_q <= cfg_wdata_i;
    end
  end

  // Piece of curve k for a rate scaled by 1000.
  function automatic logic [hnf_pkg::PC_W-1:0] piece(
      input logic [IW-1:0] k, input logic signed [hnf_pkg::XL_W-1:0] xl);
    priority if (xl > hnf_pkg::thr_q(k, 1'b0)) begin
      return hnf_pkg::PC_W'(0);
    end else if (xl > hnf_pkg::thr_q(k, 1'b1)) begin
      return hnf_pkg::PC_W'(1);
    end else begin
      return hnf_pkg::PC_W'(2);
    end
  endfunction

  // Bracket, pieces, mass offset and first accumulator value.
  always_comb begin
    logic [hnf_pkg::M100_W-1:0]       m100;
    logic signed [hnf_pkg::D_W-1:0]   ms;
    logic signed [hnf_pkg::XL_W-1:0]  xl;
    logic [IW-1:0]                    idx;
    m100 = hnf_pkg::M100_W'(wd_mass_i) * hnf_pkg::M100_W'(100);
    ms   = $signed(hnf_pkg::D_W'(m100));
    xl   = hnf_pkg::XL_W'(log_rate_i) * hnf_pkg::XL_W'(1000);
    idx  = IW'(9);
    if (ms < hnf_pkg::knot_q(IW'(1))) begin
      idx = IW'(0);
    end else begin
      for (int j = 8; j >= 1; j--) begin
        if (ms <= hnf_pkg::knot_q(IW'(j + 1))) begin
          idx = IW'(j);
        end
      end
    end
    e_item_d.lr     = log_rate_i;
    e_item_d.idx    = idx;
    e_item_d.d      = ms - hnf_pkg::knot_q(idx);
    e_item_d.p_lo   = piece(idx, xl);
    e_item_d.p_hi   = piece(IW'(idx + 1'b1), xl);
    e_item_d.acc_lo = hnf_pkg::coef_s(idx, e_item_d.p_lo, hnf_pkg::STEP_W'(4));
    e_item_d.acc_hi = hnf_pkg::coef_s(IW'(idx + 1'b1), e_item_d.p_hi,
                                      hnf_pkg::STEP_W'(4));
  end

  // Entry stage.
  assign e_rdy      = !e_v_q || h_rdy[0];
  assign in_ready_o = e_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (e_rdy) begin
      e_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_rdy && in_valid_i) begin
      e_item_q <= e_item_d;
    end
  end

  assign h_v[0]    = e_v_q;
  assign h_item[0] = e_item_q;

  // Row of Horner cells, highest coefficient first.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    hnf_horner_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (hnf_pkg::STEP_W'(NCELL - 1 - g)),
      .valid_i (h_v[g]),
      .ready_o (h_rdy[g]),
      .item_i  (h_item[g]),
      .valid_o (h_v[g+1]),
      .ready_i (h_rdy[g+1]),
      .item_o  (h_item[g+1])
    );
  end

  hnf_curve_cvt u_cvt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eta_shift_i (eta_shift_q),
    .valid_i     (h_v[NCELL]),
    .ready_o     (h_rdy[NCELL]),
    .item_i      (h_item[NCELL]),
    .valid_o     (c_v),
    .ready_i     (c_rdy),
    .item_o      (c_item)
  );

  hnf_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v),
    .ready_o (c_rdy),
    .item_i  (c_item),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .eta_o   (eta_o),
    .sat_o   (saturated_o)
  );

endmodule
